>>> design/md5_pkg.sv
// Shared types, constants and tables for the MD5 digest core.
// No dependencies.
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    // Datapath command codes
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_BYTE    = 3'd1;  // store byte, count length
    localparam logic [2:0] CMD_PAD     = 3'd2;  // put 0x80, clear later words
    localparam logic [2:0] CMD_ZERO    = 3'd3;  // clear whole block
    localparam logic [2:0] CMD_LEN     = 3'd4;  // write length words
    localparam logic [2:0] CMD_START   = 3'd5;  // copy chain into work words
    localparam logic [2:0] CMD_ROUND   = 3'd6;  // one compression step
    localparam logic [2:0] CMD_FINISH  = 3'd7;  // fold work words into chain

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       reset_iv;   // reload initial vector, clear length
    } t_md5_cmd;

    typedef struct packed {
        logic       step_last;  // step counter at 63
        logic       pos_last;   // byte position 63
        logic       pos_hi;     // byte position >= 56
    } t_md5_stat;

    function automatic logic [31:0] sine_k(input logic [5:0] i);
        logic [31:0] t [64];
        t = '{
            32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
            32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
            32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
            32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
            32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
            32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
            32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
            32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
            32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
            32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
            32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
            32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
            32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
            32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
            32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
            32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391};
        return t[i];
    endfunction

    function automatic logic [4:0] rot_s(input logic [5:0] i);
        logic [4:0] t [16];
        t = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
              5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
        return t[{i[5:4], i[1:0]}];
    endfunction

endpackage

>>> design/md5_if.sv
// Valid/ready channel interfaces for the MD5 digest core.
// Depends on nothing.
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       has_byte;
    logic       is_last;
    modport source (output valid, message_byte, has_byte, is_last, input ready);
    modport sink   (input valid, message_byte, has_byte, is_last, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> design/md5_datapath.sv
// MD5 datapath: message block, length, chaining and working words, one step unit.
// Depends on md5_pkg.
module md5_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  md5_pkg::t_md5_cmd i_cmd,
    input  logic [1:0]       i_word_sel,
    output md5_pkg::t_md5_stat o_stat,
    output logic [31:0]      o_chain_word
);
    import md5_pkg::*;

    logic [31:0] r_blk [16];
    logic [63:0] r_len;
    logic [31:0] r_ch [4];
    logic [31:0] r_wk [4];
    logic [5:0]  r_step;

    logic [5:0]  pos;
    logic [3:0]  g;
    logic [31:0] fn, t, rt;
    logic [4:0]  s;

    assign pos = r_len[8:3];
    assign o_stat.step_last = (r_step == 6'd63);
    assign o_stat.pos_last  = (pos == 6'd63);
    assign o_stat.pos_hi    = (pos >= 6'd56);
    assign o_chain_word     = r_ch[i_word_sel];

    // Round function and message index for the current step
    always_comb begin
        case (r_step[5:4])
            2'd0: begin
                fn = (r_wk[1] & r_wk[2]) | (~r_wk[1] & r_wk[3]);
                g  = r_step[3:0];
            end
            2'd1: begin
                fn = (r_wk[1] & r_wk[3]) | (r_wk[2] & ~r_wk[3]);
                g  = 4'((r_step[3:0] << 2) + r_step[3:0] + 4'd1);
            end
            2'd2: begin
                fn = r_wk[1] ^ r_wk[2] ^ r_wk[3];
                g  = 4'((r_step[3:0] << 1) + r_step[3:0] + 4'd5);
            end
            default: begin
                fn = r_wk[2] ^ (r_wk[1] | ~r_wk[3]);
                g  = 4'((r_step[3:0] << 3) - r_step[3:0]);
            end
        endcase
        t  = r_wk[0] + fn + sine_k(r_step) + r_blk[g];
        s  = rot_s(r_step);
        rt = (t << s) | (t >> (6'd32 - {1'b0, s}));
    end

    // Message block store
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_BYTE: begin
                if (pos[1:0] == 2'd0) r_blk[pos[5:2]] <= {24'd0, i_cmd.data};
                else r_blk[pos[5:2]][pos[1:0]*8 +: 8] <= i_cmd.data;
            end
            CMD_PAD: begin
                for (int w = 0; w < 16; w++) begin
                    if (4'(w) > pos[5:2]) r_blk[w] <= '0;
                end
                if (pos[1:0] == 2'd0) r_blk[pos[5:2]] <= 32'h80;
                else r_blk[pos[5:2]][pos[1:0]*8 +: 8] <= 8'h80;
            end
            CMD_ZERO: begin
                for (int w = 0; w < 16; w++) r_blk[w] <= '0;
            end
            CMD_LEN: begin
                r_blk[14] <= r_len[31:0];
                r_blk[15] <= r_len[63:32];
            end
            default: ;
        endcase
    end

    // Chaining, working words, length and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch   <= '{IV_A, IV_B, IV_C, IV_D};
            r_wk   <= '{default: '0};
            r_len  <= '0;
            r_step <= '0;
        end else if (i_cmd.reset_iv) begin
            r_ch  <= '{IV_A, IV_B, IV_C, IV_D};
            r_len <= '0;
        end else begin
            case (i_cmd.op)
                CMD_BYTE:  r_len <= r_len + 64'd8;
                CMD_START: r_wk  <= r_ch;
                CMD_ROUND: begin
                    r_wk[0] <= r_wk[3];
                    r_wk[3] <= r_wk[2];
                    r_wk[2] <= r_wk[1];
                    r_wk[1] <= r_wk[1] + rt;
                    r_step  <= r_step + 6'd1;
                end
                CMD_FINISH: begin
                    for (int k = 0; k < 4; k++) r_ch[k] <= r_ch[k] + r_wk[k];
                end
                default: ;
            endcase
        end
    end
endmodule

>>> design/md5_ctrl.sv
// MD5 controller: sequences byte load, padding, compressions and digest output.
// Depends on md5_pkg.
module md5_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [7:0]        i_in_byte,
    input  logic              i_in_has,
    input  logic              i_in_last,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_word_sel,
    output md5_pkg::t_md5_cmd o_cmd,
    input  md5_pkg::t_md5_stat i_stat
);
    import md5_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PAD   = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_ROUND = 4'd3;
    localparam logic [3:0] S_FIN   = 4'd4;
    localparam logic [3:0] S_ZERO  = 4'd5;
    localparam logic [3:0] S_LEN   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0] r_state, n_state;
    logic       r_last, n_last;     // item carried is_last
    logic       r_tail, n_tail;     // compressing the padded block before length
    logic [1:0] r_word, n_word;
    logic       r_done, n_done;     // length words written, final compression next

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_word_sel  = r_word;

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        n_tail  = r_tail;
        n_word  = r_word;
        o_cmd   = '{op: CMD_NONE, data: i_in_byte, reset_iv: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_last = i_in_last;
                    n_tail = 1'b0;
                    if (i_in_has) begin
                        o_cmd.op = CMD_BYTE;
                        if (i_stat.pos_last) n_state = S_START;
                        else if (i_in_last)  n_state = S_PAD;
                    end else if (i_in_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.op = CMD_PAD;
                if (i_stat.pos_hi) begin
                    n_tail  = 1'b1;
                    n_state = S_START;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_ZERO: begin
                o_cmd.op = CMD_ZERO;
                n_state  = S_LEN;
            end
            S_LEN: begin
                o_cmd.op = CMD_LEN;
                n_last   = 1'b1;
                n_tail   = 1'b0;
                n_state  = S_START;
            end
            S_START: begin
                o_cmd.op = CMD_START;
                n_state  = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.op = CMD_ROUND;
                if (i_stat.step_last) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.op = CMD_FINISH;
                // a full block during a message may still carry the end mark
                if (r_tail)      n_state = S_ZERO;
                else if (r_last) n_state = r_done ? S_OUT : S_PAD;
                else             n_state = S_IDLE;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_word = r_word + 2'd1;
                    if (r_word == 2'd3) begin
                        o_cmd.reset_iv = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Length written means the next compression is the final one
    always_comb begin
        n_done = r_done;
        if (r_state == S_LEN) n_done = 1'b1;
        else if (r_state == S_IDLE) n_done = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_tail  <= 1'b0;
            r_word  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_tail  <= n_tail;
            r_word  <= n_word;
            r_done  <= n_done;
        end
    end
endmodule

>>> design/md5_message_digest_core.sv
// MD5 digest core top level: controller plus datapath behind valid/ready channels.
// Order of work: a byte is accepted alone, or, when it fills a block, followed by start,
// 64 steps of the one step unit, and fold. An end item adds pad and length, then a
// compression (a long tail adds a further compression and a zero step), then four output words.
// Throughput: one byte per cycle between blocks; no byte is taken while a block compresses.
// Synchronous active-low reset loads the initial vector. Depends on md5_pkg, md5_if,
// md5_ctrl, md5_datapath.
module md5_message_digest_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    md5_in_if.sink      i_in,
    md5_out_if.source   o_out
);
    import md5_pkg::*;

    t_md5_cmd  cmd;
    t_md5_stat stat;
    logic [1:0] word_sel;

    md5_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_byte   (i_in.message_byte),
        .i_in_has    (i_in.has_byte),
        .i_in_last   (i_in.is_last),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_word_sel  (word_sel),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    md5_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_word_sel   (word_sel),
        .o_stat       (stat),
        .o_chain_word (o_out.digest_word)
    );

    assign o_out.word_index = word_sel;
    assign o_out.last_word  = (word_sel == 2'd3);

    // Input and output never both open
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("in and out both open");
    // Digest words leave in order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last_word |=>
        o_out.valid && o_out.word_index == $past(o_out.word_index) + 2'd1)
        else $error("digest word order");
    // Output begins at word A
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> o_out.word_index == 2'd0) else $error("first word");
endmodule
